// ===== rtl/qpi_pkg.sv =====
// Shared types and constants for the quintic position interpolator.
// No dependencies; imported by qpi_engine and the core top level.
package qpi_pkg;

    // default widths, handed down as module parameters
    localparam int POSITION_BITS_DEF = 12;
    localparam int TICK_BITS_DEF     = 10;
    localparam int FRACTION_BITS_DEF = 16;

    // motion length after reset
    localparam int MOTION_LEN_RESET = 100;

    // fraction bits of the internal blend arithmetic
    localparam int INT_FRAC = 32;

    // command carried in tuser
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_ABORT = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // engine status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_status;

endpackage

// ===== rtl/qpi_engine.sv =====
// Bit-serial arithmetic engine: ratio division, powers r^2..r^5, blend, scaling, rounding.
// Depends on qpi_pkg.
module qpi_engine
    import qpi_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int TICK_BITS     = TICK_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [TICK_BITS-1:0]     i_tick_num,
    input  logic [TICK_BITS-1:0]     i_total,
    input  logic [POSITION_BITS-1:0] i_origin,
    input  logic [POSITION_BITS:0]   i_delta,
    output t_eng_status              o_status,
    output logic [POSITION_BITS-1:0] o_target
);

    localparam int QW        = INT_FRAC;
    localparam int RSHIFT    = QW - FRACTION_BITS;
    localparam int BW        = QW + 6;           // signed blend accumulator
    localparam int CW        = QW + 1;           // clamped blend, [0, 1]
    localparam int HW        = CW + 2;           // product high part, signed
    localparam int DW        = POSITION_BITS + 1;
    localparam int SW        = HW + DW + 1;
    localparam int UW        = SW - QW;
    localparam int STEPS_A   = (FRACTION_BITS > QW) ? FRACTION_BITS : QW;
    localparam int STEPS_MAX = (DW > STEPS_A) ? DW : STEPS_A;
    localparam int CNT_W     = $clog2(STEPS_MAX);
    localparam int BLEND_STEPS = 6;

    typedef enum logic [7:0] {
        E_IDLE  = 8'b0000_0001,
        E_DIV   = 8'b0000_0010,
        E_MUL   = 8'b0000_0100,
        E_BLEND = 8'b0000_1000,
        E_CLAMP = 8'b0001_0000,
        E_SCALE = 8'b0010_0000,
        E_SUM   = 8'b0100_0000,
        E_FIN   = 8'b1000_0000
    } t_estate;

    t_estate                   r_state, n_state;
    logic                      r_done, n_done;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [1:0]                r_pass, n_pass;
    logic [TICK_BITS-1:0]      r_total, n_total;
    logic [TICK_BITS-1:0]      r_rem, n_rem;
    logic [FRACTION_BITS-1:0]  r_quot, n_quot;
    logic [QW-1:0]             r_rpow, n_rpow;
    logic [QW-1:0]             r_mplier, n_mplier;
    logic [QW-1:0]             r_mcand, n_mcand;
    logic [QW-1:0]             r_hi, n_hi;
    logic [QW-1:0]             r_p3, n_p3;
    logic [QW-1:0]             r_p4, n_p4;
    logic signed [BW-1:0]      r_acc, n_acc;
    logic [CW-1:0]             r_blend, n_blend;
    logic [POSITION_BITS-1:0]  r_origin, n_origin;
    logic [DW-1:0]             r_dshift, n_dshift;
    logic signed [HW-1:0]      r_phi, n_phi;
    logic [DW-1:0]             r_plo, n_plo;
    logic signed [SW-1:0]      r_sum, n_sum;
    logic [POSITION_BITS-1:0]  r_result, n_result;

    // datapath slices
    logic [TICK_BITS:0]        rem2;
    logic                      rem_ge;
    logic [TICK_BITS:0]        rem_sub;
    logic [QW:0]               msum;
    logic signed [BW-1:0]      p3e, p4e, p5e, term;
    logic [CW-1:0]             clamped;
    logic signed [HW:0]        bext, addend, ssum;
    logic signed [SW-1:0]      prod_ext, origin_ext, half;
    logic [UW-1:0]             upper;
    logic [POSITION_BITS-1:0]  rounded;
    logic [QW-1:0]             quot_wide;

    always_comb begin
        // restoring division, one quotient bit per cycle
        rem2    = {r_rem, 1'b0};
        rem_ge  = (rem2 >= {1'b0, r_total});
        rem_sub = rem2 - {1'b0, r_total};

        // shift-add multiply, high half only
        msum = {1'b0, r_hi} + (r_mplier[0] ? {1'b0, r_mcand} : {(QW+1){1'b0}});

        // blend terms: +10 p3, -15 p4, +6 p5
        p3e = $signed({{(BW-QW){1'b0}}, r_p3});
        p4e = $signed({{(BW-QW){1'b0}}, r_p4});
        p5e = $signed({{(BW-QW){1'b0}}, r_mcand});
        unique case (r_cnt)
            CNT_W'(0): term = p3e <<< 3;
            CNT_W'(1): term = p3e <<< 1;
            CNT_W'(2): term = -(p4e <<< 4);
            CNT_W'(3): term = p4e;
            CNT_W'(4): term = p5e <<< 2;
            CNT_W'(5): term = p5e <<< 1;
            default:   term = '0;
        endcase

        if (r_acc < 0) begin
            clamped = '0;
        end else if (r_acc > $signed(BW'(1) << QW)) begin
            clamped = CW'(1) << QW;
        end else begin
            clamped = r_acc[CW-1:0];
        end

        // signed serial multiply over delta bits, MSB weighs negative
        bext = $signed({3'b000, r_blend});
        if (!r_dshift[0]) begin
            addend = '0;
        end else if (r_cnt == CNT_W'(DW-1)) begin
            addend = -bext;
        end else begin
            addend = bext;
        end
        ssum = {r_phi[HW-1], r_phi} + addend;

        prod_ext   = $signed({r_phi[HW-1], r_phi, r_plo});
        origin_ext = $signed({{(SW-POSITION_BITS-QW){1'b0}}, r_origin, {QW{1'b0}}});
        half       = $signed(SW'(1) << (QW-1));

        upper = r_sum[SW-1:QW];
        if (r_sum[SW-1]) begin
            rounded = '0;
        end else if (upper > UW'({POSITION_BITS{1'b1}})) begin
            rounded = '1;
        end else begin
            rounded = upper[POSITION_BITS-1:0];
        end

        quot_wide = QW'({r_quot[FRACTION_BITS-2:0], rem_ge}) << RSHIFT;
    end

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_pass   = r_pass;
        n_total  = r_total;
        n_rem    = r_rem;
        n_quot   = r_quot;
        n_rpow   = r_rpow;
        n_mplier = r_mplier;
        n_mcand  = r_mcand;
        n_hi     = r_hi;
        n_p3     = r_p3;
        n_p4     = r_p4;
        n_acc    = r_acc;
        n_blend  = r_blend;
        n_origin = r_origin;
        n_dshift = r_dshift;
        n_phi    = r_phi;
        n_plo    = r_plo;
        n_sum    = r_sum;
        n_result = r_result;

        unique case (r_state)
            E_IDLE: begin
                if (i_start) begin
                    n_total  = i_total;
                    n_rem    = i_tick_num;
                    n_origin = i_origin;
                    n_dshift = i_delta;
                    n_cnt    = '0;
                    n_state  = E_DIV;
                end
            end
            E_DIV: begin
                n_rem  = rem_ge ? rem_sub[TICK_BITS-1:0] : rem2[TICK_BITS-1:0];
                n_quot = {r_quot[FRACTION_BITS-2:0], rem_ge};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRACTION_BITS-1)) begin
                    n_rpow   = quot_wide;
                    n_mcand  = quot_wide;
                    n_mplier = quot_wide;
                    n_hi     = '0;
                    n_cnt    = '0;
                    n_pass   = '0;
                    n_state  = E_MUL;
                end
            end
            E_MUL: begin
                n_hi     = msum[QW:1];
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QW-1)) begin
                    n_mcand  = msum[QW:1];
                    n_hi     = '0;
                    n_mplier = r_rpow;
                    n_cnt    = '0;
                    n_pass   = r_pass + 1'b1;
                    if (r_pass == 2'd1) begin
                        n_p3 = msum[QW:1];
                    end
                    if (r_pass == 2'd2) begin
                        n_p4 = msum[QW:1];
                    end
                    if (r_pass == 2'd3) begin
                        n_acc   = '0;
                        n_state = E_BLEND;
                    end
                end
            end
            E_BLEND: begin
                n_acc = r_acc + term;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(BLEND_STEPS-1)) begin
                    n_state = E_CLAMP;
                end
            end
            E_CLAMP: begin
                n_blend = clamped;
                n_phi   = '0;
                n_plo   = '0;
                n_cnt   = '0;
                n_state = E_SCALE;
            end
            E_SCALE: begin
                n_phi    = ssum[HW:1];
                n_plo    = {ssum[0], r_plo[DW-1:1]};
                n_dshift = r_dshift >> 1;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DW-1)) begin
                    n_state = E_SUM;
                end
            end
            E_SUM: begin
                n_sum   = origin_ext + prod_ext + half;
                n_state = E_FIN;
            end
            E_FIN: begin
                n_result = rounded;
                n_done   = 1'b1;
                n_state  = E_IDLE;
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_pass   <= n_pass;
        r_total  <= n_total;
        r_rem    <= n_rem;
        r_quot   <= n_quot;
        r_rpow   <= n_rpow;
        r_mplier <= n_mplier;
        r_mcand  <= n_mcand;
        r_hi     <= n_hi;
        r_p3     <= n_p3;
        r_p4     <= n_p4;
        r_acc    <= n_acc;
        r_blend  <= n_blend;
        r_origin <= n_origin;
        r_dshift <= n_dshift;
        r_phi    <= n_phi;
        r_plo    <= n_plo;
        r_sum    <= n_sum;
        r_result <= n_result;
    end

    assign o_status.busy = (r_state != E_IDLE);
    assign o_status.done = r_done;
    assign o_target      = r_result;

endmodule

// ===== rtl/quintic_position_interpolator_core.sv =====
// Top level of the quintic position interpolator: stream ports, motion state, output register.
// Depends on qpi_pkg and qpi_engine.
// Load, abort and no-op items are handled without leaving S_IDLE; a final tick goes from
// the pending register through S_HOLD into the output register. An interpolated tick is
// computed by the bit-serial engine: one quotient bit a cycle, four shift-add multiplies for
// r^2..r^5, a blend and clamp, then a serial scale by the travel. The input reopens once the
// result moves into the output register, which waits while m_axis_tready holds it off.
// Reset (synchronous, active low) disarms, clears position state, sets the motion length to 100.
module quintic_position_interpolator_core
    import qpi_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int TICK_BITS     = TICK_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int IN_W         = ((2*POSITION_BITS + 7) / 8) * 8,
    localparam int OUT_W        = ((POSITION_BITS + TICK_BITS + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [IN_W-1:0]             s_axis_tdata,   // start_position, goal_position, zero pad
    input  logic [1:0]                  s_axis_tuser,   // cmd
    // result items
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OUT_W-1:0]            m_axis_tdata,   // target_position, tick_index, zero pad
    output logic                        m_axis_tlast,   // last
    // motion length register
    input  logic                        i_cfg_wen,
    input  logic [TICK_BITS-1:0]        i_cfg_wdata
);

    // S_RUN: engine busy on an interpolated tick. S_HOLD: result ready, waiting
    // for the output register to free up.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_armed, n_armed;
    logic [TICK_BITS-1:0]       r_total, n_total;
    logic [POSITION_BITS-1:0]   r_origin, n_origin;
    logic [POSITION_BITS:0]     r_delta, n_delta;       // goal minus start, two's complement
    logic [TICK_BITS-1:0]       r_tick_count, n_tick_count;
    logic [POSITION_BITS-1:0]   r_pend_target, n_pend_target;
    logic [TICK_BITS-1:0]       r_pend_index, n_pend_index;
    logic                       r_pend_last, n_pend_last;
    logic                       r_out_valid, n_out_valid;
    logic [POSITION_BITS-1:0]   r_out_target, n_out_target;
    logic [TICK_BITS-1:0]       r_out_index, n_out_index;
    logic                       r_out_last, n_out_last;

    t_cmd                       cmd;
    logic [POSITION_BITS-1:0]   start_pos, goal_in;
    logic [TICK_BITS-1:0]       total_eff;
    logic [TICK_BITS:0]         tick_next;
    logic                       is_last;
    logic [POSITION_BITS-1:0]   goal_pos;
    logic                       accept;
    logic                       eng_start;
    t_eng_status                eng_status;
    logic [POSITION_BITS-1:0]   eng_target;

    assign cmd       = t_cmd'(s_axis_tuser);
    assign start_pos = s_axis_tdata[POSITION_BITS-1:0];
    assign goal_in   = s_axis_tdata[2*POSITION_BITS-1:POSITION_BITS];

    // zero total behaves as one: the first tick is also the last
    assign total_eff = (r_total == '0) ? TICK_BITS'(1) : r_total;
    assign tick_next = {1'b0, r_tick_count} + 1'b1;
    assign is_last   = (tick_next >= {1'b0, total_eff});
    // final tick lands exactly on the goal
    assign goal_pos  = r_origin + r_delta[POSITION_BITS-1:0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state       = r_state;
        n_armed       = r_armed;
        n_total       = r_total;
        n_origin      = r_origin;
        n_delta       = r_delta;
        n_tick_count  = r_tick_count;
        n_pend_target = r_pend_target;
        n_pend_index  = r_pend_index;
        n_pend_last   = r_pend_last;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_target  = r_out_target;
        n_out_index   = r_out_index;
        n_out_last    = r_out_last;
        eng_start     = 1'b0;

        if (i_cfg_wen) begin
            n_total = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        CMD_LOAD: begin
                            n_origin     = start_pos;
                            n_delta      = {1'b0, goal_in} - {1'b0, start_pos};
                            n_tick_count = '0;
                            n_armed      = 1'b1;
                        end
                        CMD_TICK: begin
                            if (r_armed) begin
                                n_tick_count = tick_next[TICK_BITS-1:0];
                                n_pend_index = tick_next[TICK_BITS-1:0];
                                if (is_last) begin
                                    n_pend_target = goal_pos;
                                    n_pend_last   = 1'b1;
                                    n_armed       = 1'b0;
                                    n_state       = S_HOLD;
                                end else begin
                                    n_pend_last = 1'b0;
                                    eng_start   = 1'b1;
                                    n_state     = S_RUN;
                                end
                            end
                        end
                        CMD_ABORT: begin
                            n_armed = 1'b0;
                        end
                        CMD_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (eng_status.done) begin
                    n_pend_target = eng_target;
                    n_state       = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_target = r_pend_target;
                    n_out_index  = r_pend_index;
                    n_out_last   = r_pend_last;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_armed      <= 1'b0;
            r_total      <= TICK_BITS'(MOTION_LEN_RESET);
            r_origin     <= '0;
            r_delta      <= '0;
            r_tick_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_armed      <= n_armed;
            r_total      <= n_total;
            r_origin     <= n_origin;
            r_delta      <= n_delta;
            r_tick_count <= n_tick_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_target <= n_pend_target;
        r_pend_index  <= n_pend_index;
        r_pend_last   <= n_pend_last;
        r_out_target  <= n_out_target;
        r_out_index   <= n_out_index;
        r_out_last    <= n_out_last;
    end

    qpi_engine #(
        .POSITION_BITS (POSITION_BITS),
        .TICK_BITS     (TICK_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (eng_start),
        .i_tick_num (tick_next[TICK_BITS-1:0]),
        .i_total    (total_eff),
        .i_origin   (r_origin),
        .i_delta    (r_delta),
        .o_status   (eng_status),
        .o_target   (eng_target)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_W'({r_out_index, r_out_target});

    // nothing disarms the motion while the engine works on a tick
    a_run_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_armed)
        else $error("motion disarmed during interpolation");

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_status.done |-> r_state == S_RUN)
        else $error("engine finished outside of a running tick");

    a_run_engine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> (eng_status.busy || eng_status.done))
        else $error("waiting on an idle engine");

    a_out_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_HOLD))
        else $error("output loaded without a pending result");

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for quintic_position_interpolator_core: directed rows, then random
// motions under several stall mixes, checked against an in-bench set-point predictor.
// Depends on rtl/qpi_pkg.sv and rtl/quintic_position_interpolator_core.sv.
module tb
    import qpi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W  = POSITION_BITS_DEF;
    localparam int TICK_W = TICK_BITS_DEF;
    localparam int FRAC_W = FRACTION_BITS_DEF;
    localparam int IN_W   = ((2 * POS_W + 7) / 8) * 8;
    localparam int OUT_W  = ((POS_W + TICK_W + 7) / 8) * 8;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // quiet time before a register write, after every booked set-point has come out
    localparam int SETTLE_CYCLES  = 200;
    // long receiver hold-off, enough for the engine to finish two ticks and back up the input
    localparam int HOLD_CYCLES    = 800;
    // watchdog limit on a stretch without any handshake: hold-off + one tick + settle, times four
    localparam int WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + 170 + SETTLE_CYCLES);
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 180;   // useful items per random phase
    localparam int RETUNE_ITEMS   = 64;    // new motion length this often within a phase

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [POS_W-1:0]  target;
        logic [TICK_W-1:0] index;
        logic              last;
    } t_setpoint;

    typedef struct {
        t_row_kind         kind;
        t_cmd              cmd;
        logic [POS_W-1:0]  start_pos;
        logic [POS_W-1:0]  goal_pos;
        logic              typed;      // exp holds a hand-written set-point
        t_setpoint         exp;
        logic [TICK_W-1:0] cfg_value;
    } t_stim_row;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;   // start_position, goal_position, zero pad
    logic [1:0]        s_axis_tuser  = CMD_NOP;  // cmd
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;         // target_position, tick_index, zero pad
    logic              m_axis_tlast;         // last
    logic              i_cfg_wen     = 1'b0;
    logic [TICK_W-1:0] i_cfg_wdata   = '0;

    quintic_position_interpolator_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Motion predictor state (mirrors the block after reset)
    // ------------------------------------------------------------------
    logic [TICK_W-1:0] total_cfg    = TICK_W'(MOTION_LEN_RESET);
    logic [POS_W-1:0]  origin_pos   = '0;
    int                travel       = 0;    // goal minus start, signed
    logic [TICK_W-1:0] ticks_done   = '0;
    logic              motion_armed = 1'b0;

    t_setpoint pending_setpoints[$];

    // bench bookkeeping
    int  tx_gap_pct   = 0;
    int  rx_stall_pct = 0;
    int  base_tx_pct  = 0;
    int  base_rx_pct  = 0;
    bit  hold_request = 1'b0;
    int  hold_left    = 0;
    int  mismatches   = 0;
    int  items_sent   = 0;
    int  useful_items = 0;
    int  loads_sent   = 0;
    int  motion_ends  = 0;
    int  results_seen = 0;
    int  cfg_writes   = 0;

    // Blend 10r^3 - 15r^4 + 6r^5 with truncated Q.32 powers, then origin + travel * blend,
    // rounded half up and clamped to the position range.
    function automatic logic [POS_W-1:0] blend_position(input longint unsigned n,
                                                        input longint unsigned total);
        longint unsigned ratio, r32, p2, p3, p4, p5, rounded;
        longint          blend, sum;
        ratio = (n << FRAC_W) / total;
        r32   = ratio << (INT_FRAC - FRAC_W);
        p2    = (r32 * r32) >> INT_FRAC;
        p3    = (p2 * r32) >> INT_FRAC;
        p4    = (p3 * r32) >> INT_FRAC;
        p5    = (p4 * r32) >> INT_FRAC;
        blend = 10 * longint'(p3) - 15 * longint'(p4) + 6 * longint'(p5);
        if (blend < 0) begin
            blend = 0;
        end
        if (blend > (longint'(1) << INT_FRAC)) begin
            blend = longint'(1) << INT_FRAC;
        end
        sum = (longint'(origin_pos) << INT_FRAC) + longint'(travel) * blend;
        if (sum < 0) begin
            sum = 0;
        end
        rounded = ($unsigned(sum) + (64'd1 << (INT_FRAC - 1))) >> INT_FRAC;
        if (rounded > longint'(POS_MAX)) begin
            rounded = longint'(POS_MAX);
        end
        return rounded[POS_W-1:0];
    endfunction

    // Applies one accepted item to the motion state; returns 1 when it yields a set-point.
    function automatic logic advance_motion(input t_cmd cmd, input logic [POS_W-1:0] start_pos,
                                            input logic [POS_W-1:0] goal_pos,
                                            output t_setpoint sp);
        int total, n;
        sp = '0;
        case (cmd)
            CMD_LOAD: begin
                origin_pos   = start_pos;
                travel       = int'(goal_pos) - int'(start_pos);
                ticks_done   = '0;
                motion_armed = 1'b1;
                return 1'b0;
            end
            CMD_ABORT: begin
                motion_armed = 1'b0;
                return 1'b0;
            end
            CMD_TICK: begin
                if (!motion_armed) begin
                    return 1'b0;
                end
                total = (total_cfg == 0) ? 1 : int'(total_cfg);
                n     = int'(ticks_done) + 1;
                if (n >= total) begin
                    // final tick lands exactly on the goal
                    sp.target    = POS_W'(int'(origin_pos) + travel);
                    sp.last      = 1'b1;
                    motion_armed = 1'b0;
                end else begin
                    sp.target = blend_position(n, total);
                end
                sp.index   = TICK_W'(n);
                ticks_done = TICK_W'(n);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offers one item, waits for the handshake, then books the predicted set-point.
    // tvalid is left high so a following item goes out back to back.
    task automatic send_item(input t_cmd cmd, input logic [POS_W-1:0] start_pos,
                             input logic [POS_W-1:0] goal_pos, input logic typed,
                             input t_setpoint typed_sp);
        t_setpoint sp;
        logic      was_armed, produced;
        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({goal_pos, start_pos});
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        was_armed = motion_armed;
        produced  = advance_motion(cmd, start_pos, goal_pos, sp);
        if (produced) begin
            pending_setpoints.push_back(typed ? typed_sp : sp);
            if (sp.last) begin
                motion_ends++;
            end
        end
        items_sent++;
        if (cmd == CMD_LOAD) begin
            loads_sent++;
        end
        if (cmd == CMD_LOAD || produced || (cmd == CMD_ABORT && was_armed)) begin
            useful_items++;
        end
    endtask

    // Drop tvalid, wait for every booked set-point, then idle for SETTLE_CYCLES.
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_setpoints.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // the motion length is only written with the block idle
    task automatic write_total(input logic [TICK_W-1:0] value);
        drain_and_settle();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        total_cfg    = value;
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] random_position();
        if ($urandom_range(4) == 0) begin
            return $urandom_range(1) ? POS_MAX : '0;
        end
        return POS_W'($urandom_range(int'(POS_MAX)));
    endfunction

    // Mostly short motions; one, zero and near-maximum durations now and then.
    function automatic logic [TICK_W-1:0] random_total();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) return TICK_W'($urandom_range(2, 16));
        if (pick < 75) return TICK_W'($urandom_range(17, 60));
        if (pick < 85) return TICK_W'(1);
        if (pick < 90) return '0;
        return TICK_W'($urandom_range(900, 1023));
    endfunction

    // One random sequence: a well-formed motion with random content (sometimes aborted or
    // restarted), or a burst of raw noise items.
    task automatic random_sequence();
        int eff_total, n_ticks, cut, i;
        int style;
        if ($urandom_range(99) < 15) begin
            // stretch without any idling
            tx_gap_pct   = 0;
            rx_stall_pct = 0;
        end else begin
            tx_gap_pct   = base_tx_pct;
            rx_stall_pct = base_rx_pct;
        end
        if ($urandom_range(99) < 80) begin
            eff_total = (total_cfg == 0) ? 1 : int'(total_cfg);
            // long motions are cut short; the next load restarts them
            n_ticks = (eff_total > 40) ? $urandom_range(1, 40) : eff_total;
            style   = $urandom_range(19);
            cut     = $urandom_range(n_ticks - 1);
            send_item(CMD_LOAD, random_position(), random_position(), 1'b0, '0);
            for (i = 0; i < n_ticks; i++) begin
                if (i == cut && style == 0) begin
                    send_item(CMD_ABORT, random_position(), random_position(), 1'b0, '0);
                    break;
                end
                if (i == cut && style == 1) begin
                    send_item(CMD_LOAD, random_position(), random_position(), 1'b0, '0);
                end
                send_item(CMD_TICK, random_position(), random_position(), 1'b0, '0);
            end
            if (style == 2) begin
                // extra tick: ignored by the block once the motion has ended
                send_item(CMD_TICK, '0, '0, 1'b0, '0);
            end
        end else begin
            repeat ($urandom_range(1, 4)) begin
                send_item(t_cmd'($urandom_range(3)), random_position(), random_position(),
                          1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Directed rows. Typed set-points are the obvious ones: single-tick motions and final ticks
    // land on the goal, and a motion with no travel stays put.
    // ------------------------------------------------------------------
    t_stim_row directed_rows [30] = '{
        // tick, abort and no-op straight after reset: nothing comes out
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_ABORT, 12'd0,    12'd0,    1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_NOP,   12'd4095, 12'd4095, 1'b0, '0, 10'd0},
        // reset duration (100), first step of a full-range move, then abort and an ignored tick
        '{ROW_ITEM, CMD_LOAD,  12'd0,    12'd4095, 1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_ABORT, 12'd0,    12'd0,    1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b0, '0, 10'd0},
        // one-tick motions in both directions
        '{ROW_CFG,  CMD_NOP,   12'd0,    12'd0,    1'b0, '0, 10'd1},
        '{ROW_ITEM, CMD_LOAD,  12'd0,    12'd4095, 1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b1, {12'd4095, 10'd1, 1'b1}, 10'd0},
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_LOAD,  12'd4095, 12'd0,    1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b1, {12'd0, 10'd1, 1'b1}, 10'd0},
        // zero duration behaves as one tick
        '{ROW_CFG,  CMD_NOP,   12'd0,    12'd0,    1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_LOAD,  12'd2730, 12'd1365, 1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b1, {12'd1365, 10'd1, 1'b1}, 10'd0},
        // longest duration, restart while armed
        '{ROW_CFG,  CMD_NOP,   12'd0,    12'd0,    1'b0, '0, 10'd1023},
        '{ROW_ITEM, CMD_LOAD,  12'd4095, 12'd0,    1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_LOAD,  12'd0,    12'd4095, 1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b0, '0, 10'd0},
        // duration lowered mid-motion: next tick is the last one
        '{ROW_CFG,  CMD_NOP,   12'd0,    12'd0,    1'b0, '0, 10'd2},
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b1, {12'd4095, 10'd2, 1'b1}, 10'd0},
        // motion with no travel; a no-op in the middle changes nothing
        '{ROW_CFG,  CMD_NOP,   12'd0,    12'd0,    1'b0, '0, 10'd3},
        '{ROW_ITEM, CMD_LOAD,  12'd100,  12'd100,  1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_NOP,   12'd4095, 12'd0,    1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b1, {12'd100, 10'd1, 1'b0}, 10'd0},
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b0, '0, 10'd0},
        '{ROW_ITEM, CMD_TICK,  12'd0,    12'd0,    1'b1, {12'd100, 10'd3, 1'b1}, 10'd0}
    };

    // ------------------------------------------------------------------
    // Receiver: checks each set-point against the oldest booked one, drives tready
    // ------------------------------------------------------------------
    task automatic check_setpoint();
        t_setpoint got, want;
        got.target = m_axis_tdata[POS_W-1:0];
        got.index  = m_axis_tdata[POS_W +: TICK_W];
        got.last   = m_axis_tlast;
        results_seen++;
        if (pending_setpoints.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%t: unexpected set-point target=%0d index=%0d last=%0b",
                         $realtime, got.target, got.index, got.last);
            end
        end else begin
            want = pending_setpoints.pop_front();
            if (got.target !== want.target || got.index !== want.index
                    || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%t: set-point wrong: expected target=%0d index=%0d last=%0b,",
                             $realtime, want.target, want.index, want.last,
                             " got target=%0d index=%0d last=%0b",
                             got.target, got.index, got.last);
                end
            end
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                check_setpoint();
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // Watchdog: too long without any handshake on either side ends the run.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%t: no handshake for %0d cycles, %0d set-points outstanding",
                         $realtime, quiet_cycles, pending_setpoints.size());
                $display("quintic_position_interpolator_core: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int         phase_start, retune_mark;
        t_idle_mode mode;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_total(directed_rows[i].cfg_value);
            end else begin
                send_item(directed_rows[i].cmd, directed_rows[i].start_pos,
                          directed_rows[i].goal_pos, directed_rows[i].typed,
                          directed_rows[i].exp);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            mode = t_idle_mode'(phase % 4);
            case (mode)
                IDLE_NONE: begin
                    base_tx_pct = 0;
                    base_rx_pct = 0;
                end
                IDLE_SENDER: begin
                    base_tx_pct = 55;
                    base_rx_pct = 0;
                end
                IDLE_RECEIVER: begin
                    base_tx_pct = 0;
                    base_rx_pct = 55;
                end
                default: begin
                    base_tx_pct = 38;
                    base_rx_pct = 38;
                end
            endcase
            // the first phase keeps whatever duration the directed part left behind;
            // an armed motion may carry over into a new duration
            if (phase != 0) begin
                write_total(random_total());
            end
            if (phase == 4) begin
                // receiver backs off for a long while; input keeps coming and must stall
                hold_request = 1'b1;
            end
            phase_start = useful_items;
            retune_mark = useful_items;
            while (useful_items - phase_start < PHASE_ITEMS) begin
                random_sequence();
                if (useful_items - retune_mark >= RETUNE_ITEMS) begin
                    write_total(random_total());
                    retune_mark = useful_items;
                end
            end
            // sender pauses until the pipeline is empty
            drain_and_settle();
        end
        // the extremes once more at the end of the run
        write_total(TICK_W'(1023));
        send_item(CMD_LOAD, random_position(), random_position(), 1'b0, '0);
        repeat (3) send_item(CMD_TICK, '0, '0, 1'b0, '0);
        write_total(TICK_W'(1));
        send_item(CMD_TICK, '0, '0, 1'b0, '0);

        drain_and_settle();
        $display("run covered %0d items (%0d loads, %0d completed motions) and %0d writes",
                 items_sent, loads_sent, motion_ends, cfg_writes);
        $display("of the motion length; %0d set-points checked, %0d wrong, %0d left outstanding",
                 results_seen, mismatches, pending_setpoints.size());
        if (mismatches == 0 && pending_setpoints.size() == 0) begin
            $display("quintic_position_interpolator_core: match");
        end else begin
            $display("quintic_position_interpolator_core: mismatch");
        end
        $finish;
    end

endmodule
